// ===== hdl/sdspi_pkg.sv =====
// shared types and constants of the sd card spi transaction engine
package sdspi_pkg;

    localparam int unsigned TGT_W       = 13;
    localparam int unsigned FRAME_W     = 48;
    localparam int unsigned FRAME_BYTES = 6;
    localparam int unsigned CRC_BYTES   = 2;
    localparam int unsigned RESP_MAX    = 5;

    localparam logic [7:0] BYTE_IDLE     = 8'hFF;
    localparam logic [7:0] TOKEN_START   = 8'hFE;
    localparam logic [7:0] MASK_RESP     = 8'h80;
    localparam logic [7:0] MASK_ERR_TOK  = 8'hE0;
    localparam logic [1:0] CMD_PREFIX    = 2'b01;
    localparam logic [7:0] POLL_LIM_RST  = 8'd8;
    localparam logic [7:0] IDLE_CLK_RST  = 8'd10;

    typedef enum logic [1:0] {
        CMD_COMMAND = 2'd0,
        CMD_READ    = 2'd1,
        CMD_IDLE    = 2'd2,
        CMD_XCHG    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NORESP  = 2'd1,
        ST_DATAERR = 2'd2,
        ST_BUSY    = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        REG_POLL_LIMIT = 1'b0,
        REG_IDLE_CLKS  = 1'b1
    } t_reg;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_DUMMY  = 4'd1,
        PH_CPRE   = 4'd2,
        PH_CFRAME = 4'd3,
        PH_CPOLL  = 4'd4,
        PH_CRESP  = 4'd5,
        PH_RPRE   = 4'd6,
        PH_RWAIT  = 4'd7,
        PH_RDATA  = 4'd8,
        PH_RCRC   = 4'd9,
        PH_TAIL   = 4'd10
    } t_phase;

    typedef struct packed {
        t_cmd               kind;
        logic [FRAME_W-1:0] frame;
        logic [2:0]         resp_tgt;
        logic [TGT_W-1:0]   data_tgt;
        logic               sel;
        logic [7:0]         rx;
    } t_item;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       cs_active;
        logic       out_valid;
        logic [7:0] out_byte;
        logic       out_is_data;
        logic       out_last;
        logic       done;
        t_status    status;
    } t_result;

endpackage

// ===== hdl/sdspi_front.sv =====
// request decode: command frame assembly and length saturation
module sdspi_front #(
    parameter int unsigned MAX_BLOCK_BYTES = 4096
) (
    input  logic [1:0]                      i_cmd,
    input  logic [5:0]                      i_command_index,
    input  logic [31:0]                     i_argument,
    input  logic [7:0]                      i_crc_byte,
    input  logic [2:0]                      i_response_length,
    input  logic [sdspi_pkg::TGT_W-1:0]     i_data_length,
    input  logic                            i_select_card,
    input  logic [7:0]                      i_rx_byte,
    output sdspi_pkg::t_item                o_item
);

    logic [2:0]                  resp_sat;
    logic [sdspi_pkg::TGT_W-1:0] data_sat;

    always_comb begin
        resp_sat = i_response_length;
        if (i_response_length == 3'd0) begin
            resp_sat = 3'd1;
        end else if (32'(i_response_length) > 32'(sdspi_pkg::RESP_MAX)) begin
            resp_sat = 3'(sdspi_pkg::RESP_MAX);
        end
    end

    always_comb begin
        data_sat = i_data_length;
        if (i_data_length == '0) begin
            data_sat = sdspi_pkg::TGT_W'(1);
        end else if (32'(i_data_length) > 32'(MAX_BLOCK_BYTES)) begin
            data_sat = sdspi_pkg::TGT_W'(MAX_BLOCK_BYTES);
        end
    end

    always_comb begin
        o_item.kind     = sdspi_pkg::t_cmd'(i_cmd);
        o_item.frame    = {sdspi_pkg::CMD_PREFIX, i_command_index, i_argument, i_crc_byte};
        o_item.resp_tgt = resp_sat;
        o_item.data_tgt = data_sat;
        o_item.sel      = i_select_card;
        o_item.rx       = i_rx_byte;
    end

endmodule

// ===== hdl/sdspi_queue.sv =====
// two-entry queue between request decode and the sequencer
module sdspi_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sdspi_pkg::t_item i_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output sdspi_pkg::t_item o_item
);

    sdspi_pkg::t_item r_mem [2];
    logic             r_wptr, n_wptr;
    logic             r_rptr, n_rptr;
    logic [1:0]       r_cnt, n_cnt;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = ~r_wptr;
        end
        if (i_pop) begin
            n_rptr = ~r_rptr;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rptr];

endmodule

// ===== hdl/sdspi_back.sv =====
// transaction sequencer with configuration registers and output register
module sdspi_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [7:0]               i_cfg_data,
    input  logic                     i_q_valid,
    input  sdspi_pkg::t_item         i_q_item,
    output logic                     o_q_pop,
    output logic                     o_valid,
    input  logic                     i_ready,
    output sdspi_pkg::t_result       o_res
);

    logic [7:0] r_poll_lim;
    logic [7:0] r_idle_clks;

    sdspi_pkg::t_phase                r_phase, n_phase;
    logic [sdspi_pkg::TGT_W-1:0]      r_cnt, n_cnt;
    logic [7:0]                       r_poll, n_poll;
    logic [sdspi_pkg::FRAME_W-1:0]    r_frame, n_frame;
    logic [2:0]                       r_rtgt, n_rtgt;
    logic [sdspi_pkg::TGT_W-1:0]      r_dtgt, n_dtgt;
    logic                             r_sel, n_sel;
    sdspi_pkg::t_status               r_stat, n_stat;

    logic                             r_ovalid, n_ovalid;
    sdspi_pkg::t_result               r_res, n_res;

    logic                             pop;
    logic                             is_req;
    logic [sdspi_pkg::TGT_W-1:0]      cnt_inc;
    logic [7:0]                       poll_lim;
    logic [7:0]                       idle_lim;
    logic                             dummy_hit;
    logic                             poll_hit;
    logic                             rx_resp;
    logic                             rx_err_tok;
    logic                             rx_start;
    logic [sdspi_pkg::FRAME_W-1:0]    frame_shl;

    assign pop        = i_q_valid && (!r_ovalid || i_ready);
    assign is_req     = (i_q_item.kind != sdspi_pkg::CMD_XCHG);
    assign cnt_inc    = r_cnt + sdspi_pkg::TGT_W'(1);
    assign poll_lim   = (r_poll_lim == 8'd0) ? 8'd1 : r_poll_lim;
    assign idle_lim   = (r_idle_clks == 8'd0) ? 8'd1 : r_idle_clks;
    assign dummy_hit  = (r_cnt >= sdspi_pkg::TGT_W'(idle_lim));
    assign poll_hit   = (r_poll >= poll_lim);
    assign rx_resp    = ((i_q_item.rx & sdspi_pkg::MASK_RESP) == 8'd0);
    assign rx_err_tok = ((i_q_item.rx & sdspi_pkg::MASK_ERR_TOK) == 8'd0);
    assign rx_start   = (i_q_item.rx == sdspi_pkg::TOKEN_START);
    assign frame_shl  = {r_frame[sdspi_pkg::FRAME_W-9:0], 8'h00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_lim  <= sdspi_pkg::POLL_LIM_RST;
            r_idle_clks <= sdspi_pkg::IDLE_CLK_RST;
        end else if (i_cfg_we) begin
            case (sdspi_pkg::t_reg'(i_cfg_idx))
                sdspi_pkg::REG_POLL_LIMIT: r_poll_lim  <= i_cfg_data;
                sdspi_pkg::REG_IDLE_CLKS:  r_idle_clks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_poll  = r_poll;
        n_frame = r_frame;
        n_rtgt  = r_rtgt;
        n_dtgt  = r_dtgt;
        n_sel   = r_sel;
        n_stat  = r_stat;
        if (pop) begin
            if (is_req) begin
                if (r_phase == sdspi_pkg::PH_IDLE) begin
                    n_cnt  = '0;
                    n_poll = '0;
                    n_stat = sdspi_pkg::ST_OK;
                    case (i_q_item.kind)
                        sdspi_pkg::CMD_IDLE: begin
                            n_sel   = 1'b0;
                            n_phase = sdspi_pkg::PH_DUMMY;
                            n_cnt   = sdspi_pkg::TGT_W'(1);
                        end
                        sdspi_pkg::CMD_COMMAND: begin
                            n_sel   = i_q_item.sel;
                            n_rtgt  = i_q_item.resp_tgt;
                            n_frame = i_q_item.frame;
                            n_phase = sdspi_pkg::PH_CPRE;
                        end
                        default: begin
                            n_sel   = i_q_item.sel;
                            n_dtgt  = i_q_item.data_tgt;
                            n_phase = sdspi_pkg::PH_RPRE;
                        end
                    endcase
                end
            end else begin
                case (r_phase)
                    sdspi_pkg::PH_IDLE: ;
                    sdspi_pkg::PH_DUMMY: begin
                        if (dummy_hit) begin
                            n_phase = sdspi_pkg::PH_IDLE;
                        end else begin
                            n_cnt = cnt_inc;
                        end
                    end
                    sdspi_pkg::PH_CPRE: begin
                        n_phase = sdspi_pkg::PH_CFRAME;
                        n_cnt   = '0;
                        n_frame = frame_shl;
                    end
                    sdspi_pkg::PH_CFRAME: begin
                        n_cnt = cnt_inc;
                        if (cnt_inc < sdspi_pkg::TGT_W'(sdspi_pkg::FRAME_BYTES)) begin
                            n_frame = frame_shl;
                        end else begin
                            n_phase = sdspi_pkg::PH_CPOLL;
                            n_poll  = 8'd1;
                        end
                    end
                    sdspi_pkg::PH_CPOLL: begin
                        if (rx_resp) begin
                            if (r_rtgt <= 3'd1) begin
                                n_stat  = sdspi_pkg::ST_OK;
                                n_sel   = 1'b0;
                                n_phase = sdspi_pkg::PH_TAIL;
                            end else begin
                                n_cnt   = sdspi_pkg::TGT_W'(1);
                                n_phase = sdspi_pkg::PH_CRESP;
                            end
                        end else if (poll_hit) begin
                            n_stat  = sdspi_pkg::ST_NORESP;
                            n_sel   = 1'b0;
                            n_phase = sdspi_pkg::PH_TAIL;
                        end else begin
                            n_poll = r_poll + 8'd1;
                        end
                    end
                    sdspi_pkg::PH_CRESP: begin
                        n_cnt = cnt_inc;
                        if (cnt_inc >= sdspi_pkg::TGT_W'(r_rtgt)) begin
                            n_stat  = sdspi_pkg::ST_OK;
                            n_sel   = 1'b0;
                            n_phase = sdspi_pkg::PH_TAIL;
                        end
                    end
                    sdspi_pkg::PH_RPRE: begin
                        n_phase = sdspi_pkg::PH_RWAIT;
                    end
                    sdspi_pkg::PH_RWAIT: begin
                        if (rx_err_tok) begin
                            n_stat  = sdspi_pkg::ST_DATAERR;
                            n_sel   = 1'b0;
                            n_phase = sdspi_pkg::PH_TAIL;
                        end else if (rx_start) begin
                            n_phase = sdspi_pkg::PH_RDATA;
                            n_cnt   = '0;
                        end
                    end
                    sdspi_pkg::PH_RDATA: begin
                        if (cnt_inc >= r_dtgt) begin
                            n_phase = sdspi_pkg::PH_RCRC;
                            n_cnt   = '0;
                        end else begin
                            n_cnt = cnt_inc;
                        end
                    end
                    sdspi_pkg::PH_RCRC: begin
                        n_cnt = cnt_inc;
                        if (cnt_inc >= sdspi_pkg::TGT_W'(sdspi_pkg::CRC_BYTES)) begin
                            n_stat  = sdspi_pkg::ST_OK;
                            n_sel   = 1'b0;
                            n_phase = sdspi_pkg::PH_TAIL;
                        end
                    end
                    sdspi_pkg::PH_TAIL: begin
                        n_phase = sdspi_pkg::PH_IDLE;
                        n_sel   = 1'b0;
                    end
                    default: begin
                        n_phase = sdspi_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // result of the current beat
    always_comb begin
        n_res = '0;
        if (is_req) begin
            if (r_phase != sdspi_pkg::PH_IDLE) begin
                n_res.cs_active = r_sel;
                n_res.status    = sdspi_pkg::ST_BUSY;
            end else begin
                n_res.tx_valid  = 1'b1;
                n_res.tx_byte   = sdspi_pkg::BYTE_IDLE;
                n_res.cs_active = (i_q_item.kind == sdspi_pkg::CMD_IDLE) ? 1'b0 : i_q_item.sel;
            end
        end else begin
            case (r_phase)
                sdspi_pkg::PH_IDLE: ;
                sdspi_pkg::PH_DUMMY: begin
                    if (dummy_hit) begin
                        n_res.done = 1'b1;
                    end else begin
                        n_res.tx_valid  = 1'b1;
                        n_res.tx_byte   = sdspi_pkg::BYTE_IDLE;
                        n_res.cs_active = r_sel;
                    end
                end
                sdspi_pkg::PH_CPRE: begin
                    n_res.tx_valid  = 1'b1;
                    n_res.tx_byte   = r_frame[sdspi_pkg::FRAME_W-1 -: 8];
                    n_res.cs_active = r_sel;
                end
                sdspi_pkg::PH_CFRAME: begin
                    n_res.tx_valid  = 1'b1;
                    n_res.cs_active = r_sel;
                    if (cnt_inc < sdspi_pkg::TGT_W'(sdspi_pkg::FRAME_BYTES)) begin
                        n_res.tx_byte = r_frame[sdspi_pkg::FRAME_W-1 -: 8];
                    end else begin
                        n_res.tx_byte = sdspi_pkg::BYTE_IDLE;
                    end
                end
                sdspi_pkg::PH_CPOLL: begin
                    n_res.tx_valid = 1'b1;
                    n_res.tx_byte  = sdspi_pkg::BYTE_IDLE;
                    if (rx_resp) begin
                        n_res.out_valid = 1'b1;
                        n_res.out_byte  = i_q_item.rx;
                        if (r_rtgt <= 3'd1) begin
                            n_res.out_last = 1'b1;
                        end else begin
                            n_res.cs_active = r_sel;
                        end
                    end else if (!poll_hit) begin
                        n_res.cs_active = r_sel;
                    end
                end
                sdspi_pkg::PH_CRESP: begin
                    n_res.tx_valid  = 1'b1;
                    n_res.tx_byte   = sdspi_pkg::BYTE_IDLE;
                    n_res.out_valid = 1'b1;
                    n_res.out_byte  = i_q_item.rx;
                    if (cnt_inc >= sdspi_pkg::TGT_W'(r_rtgt)) begin
                        n_res.out_last = 1'b1;
                    end else begin
                        n_res.cs_active = r_sel;
                    end
                end
                sdspi_pkg::PH_RPRE: begin
                    n_res.tx_valid  = 1'b1;
                    n_res.tx_byte   = sdspi_pkg::BYTE_IDLE;
                    n_res.cs_active = r_sel;
                end
                sdspi_pkg::PH_RWAIT: begin
                    n_res.tx_valid  = 1'b1;
                    n_res.tx_byte   = sdspi_pkg::BYTE_IDLE;
                    n_res.cs_active = rx_err_tok ? 1'b0 : r_sel;
                end
                sdspi_pkg::PH_RDATA: begin
                    n_res.tx_valid    = 1'b1;
                    n_res.tx_byte     = sdspi_pkg::BYTE_IDLE;
                    n_res.cs_active   = r_sel;
                    n_res.out_valid   = 1'b1;
                    n_res.out_byte    = i_q_item.rx;
                    n_res.out_is_data = 1'b1;
                    n_res.out_last    = (cnt_inc >= r_dtgt);
                end
                sdspi_pkg::PH_RCRC: begin
                    n_res.tx_valid = 1'b1;
                    n_res.tx_byte  = sdspi_pkg::BYTE_IDLE;
                    if (cnt_inc < sdspi_pkg::TGT_W'(sdspi_pkg::CRC_BYTES)) begin
                        n_res.cs_active = r_sel;
                    end
                end
                sdspi_pkg::PH_TAIL: begin
                    n_res.done   = 1'b1;
                    n_res.status = r_stat;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (pop) begin
            n_ovalid = 1'b1;
        end else if (i_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= sdspi_pkg::PH_IDLE;
            r_cnt    <= '0;
            r_poll   <= '0;
            r_frame  <= '0;
            r_rtgt   <= 3'd1;
            r_dtgt   <= sdspi_pkg::TGT_W'(1);
            r_sel    <= 1'b0;
            r_stat   <= sdspi_pkg::ST_OK;
            r_ovalid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_poll   <= n_poll;
            r_frame  <= n_frame;
            r_rtgt   <= n_rtgt;
            r_dtgt   <= n_dtgt;
            r_sel    <= n_sel;
            r_stat   <= n_stat;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_res <= n_res;
        end
    end

    assign o_q_pop = pop;
    assign o_valid = r_ovalid;
    assign o_res   = r_res;

`ifndef SYNTHESIS
    a_idle_deselected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == sdspi_pkg::PH_IDLE) |-> !r_sel)
        else $error("select held while idle");

    a_done_no_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_res.done) |-> !r_res.tx_valid)
        else $error("finished beat also requests an exchange");

    a_busy_inert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_res.status == sdspi_pkg::ST_BUSY)
        |-> (!r_res.tx_valid && !r_res.done && !r_res.out_valid))
        else $error("rejected request produced activity");

    a_poll_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == sdspi_pkg::PH_CPOLL) |-> (r_poll != 8'd0 && r_poll <= poll_lim))
        else $error("poll count beyond limit");

    a_pop_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> r_ovalid)
        else $error("popped beat not registered");
`endif

endmodule

// ===== hdl/sd_spi_transaction_engine.sv =====
// top level of the sd card spi transaction engine
// Takes one beat per clock: a request (command, block read, idle clocks) or the byte
// the card returned in the last spi exchange, and answers each beat with exactly one
// result beat naming the next byte to send, the chip select level and any response or
// data byte received. Sustained rate is one beat per cycle while the output is not
// stalled. An accepted beat waits in the queue, then the sequencer steps and loads its
// output register. A two-entry queue decouples the input from the output so either side
// may stall without losing beats; with the output stalled, two beats fill the queue and
// s_axis_tready drops until a result beat is taken. The user must see that configuration
// is written only while idle; the block itself does not enforce it.
module sd_spi_transaction_engine #(
    parameter int unsigned MAX_BLOCK_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command_index, argument, crc_byte, response_length, data_length, select_card,
    // rx_byte, zero pad
    input  logic [71:0] s_axis_tdata,
    // cmd
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tx_valid, tx_byte, cs_active, out_valid, out_byte, done_res, status, zero pad
    output logic [23:0] m_axis_tdata,
    // out_is_data
    output logic        m_axis_tuser,
    // out_last
    output logic        m_axis_tlast
);

    sdspi_pkg::t_item   dec_item;
    sdspi_pkg::t_item   q_item;
    sdspi_pkg::t_result res;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    logic               push;

    assign push          = s_axis_tvalid && !q_full;
    assign s_axis_tready = !q_full;

    sdspi_front #(
        .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
    ) u_front (
        .i_cmd            (s_axis_tuser),
        .i_command_index  (s_axis_tdata[5:0]),
        .i_argument       (s_axis_tdata[37:6]),
        .i_crc_byte       (s_axis_tdata[45:38]),
        .i_response_length(s_axis_tdata[48:46]),
        .i_data_length    (s_axis_tdata[61:49]),
        .i_select_card    (s_axis_tdata[62]),
        .i_rx_byte        (s_axis_tdata[70:63]),
        .o_item           (dec_item)
    );

    sdspi_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (dec_item),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_item (q_item)
    );

    sdspi_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res     (res)
    );

    assign m_axis_tdata = {2'b00, res.status, res.done, res.out_byte, res.out_valid,
                           res.cs_active, res.tx_byte, res.tx_valid};
    assign m_axis_tuser = res.out_is_data;
    assign m_axis_tlast = res.out_last;

endmodule

// ===== tb/tb.sv =====
// self-checking testbench of the sd card spi transaction engine
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_BLOCK_BYTES = 4096;
    localparam int unsigned ITEMS           = 1900;
    localparam int unsigned STALL_LIMIT     = 2000;
    localparam int unsigned DRAIN_CYCLES    = 10;
    localparam int unsigned N_SETTINGS      = 6;

    typedef struct packed {
        sdspi_pkg::t_cmd kind;
        logic [5:0]      cmd_idx;
        logic [31:0]     arg;
        logic [7:0]      crc;
        logic [2:0]      rsp_len;
        logic [12:0]     blk_len;
        logic            sel;
        logic [7:0]      rx;
    } t_spi_in;

    typedef struct {
        t_spi_in            b;
        bit                 typed;
        sdspi_pkg::t_result want;
    } t_plan_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [7:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // command_index, argument, crc_byte, response_length, data_length, select_card,
    // rx_byte, zero pad
    logic [71:0] s_axis_tdata = '0;
    // cmd
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tx_valid, tx_byte, cs_active, out_valid, out_byte, done_res, status, zero pad
    logic [23:0] m_axis_tdata;
    // out_is_data
    logic        m_axis_tuser;
    // out_last
    logic        m_axis_tlast;

    sd_spi_transaction_engine #(
        .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [7:0]          cfg_poll_limit = sdspi_pkg::POLL_LIM_RST;
    logic [7:0]          cfg_idle_clks  = sdspi_pkg::IDLE_CLK_RST;
    sdspi_pkg::t_phase   seq_phase      = sdspi_pkg::PH_IDLE;
    logic [12:0]         seq_count      = '0;
    logic [7:0]          seq_polls      = '0;
    logic [47:0]         seq_frame      = '0;
    logic [2:0]          seq_resp_tgt   = 3'd1;
    logic [12:0]         seq_data_tgt   = 13'd1;
    logic                seq_sel        = 1'b0;
    sdspi_pkg::t_status  seq_status     = sdspi_pkg::ST_OK;

    sdspi_pkg::t_result  pending_replies[$];
    t_plan_row           plan[$];
    int unsigned mismatches  = 0;
    int unsigned n_items     = 0;
    int unsigned n_results   = 0;
    int unsigned idle_cycles = 0;
    bit          calm        = 1'b0;

    function automatic sdspi_pkg::t_result send_byte(sdspi_pkg::t_result r, logic [7:0] v);
        r.tx_valid  = 1'b1;
        r.tx_byte   = v;
        r.cs_active = seq_sel;
        return r;
    endfunction

    function automatic sdspi_pkg::t_result got_byte(sdspi_pkg::t_result r, logic [7:0] v,
                                                    logic is_data, logic last);
        r.out_valid   = 1'b1;
        r.out_byte    = v;
        r.out_is_data = is_data;
        r.out_last    = last;
        return r;
    endfunction

    function automatic sdspi_pkg::t_result finish_tail(sdspi_pkg::t_result r,
                                                       sdspi_pkg::t_status st);
        seq_status = st;
        seq_sel    = 1'b0;
        seq_phase  = sdspi_pkg::PH_TAIL;
        return send_byte(r, sdspi_pkg::BYTE_IDLE);
    endfunction

    function automatic logic [7:0] frame_byte(logic [12:0] i);
        int unsigned sh;
        sh = 40 - 8 * int'(i);
        return 8'(seq_frame >> sh);
    endfunction

    function automatic sdspi_pkg::t_result spi_sequence_step(t_spi_in b);
        sdspi_pkg::t_result r;
        logic [7:0]         lim;
        logic [2:0]         rl;
        logic [12:0]        dl;
        r = '0;
        if (b.kind != sdspi_pkg::CMD_XCHG) begin
            if (seq_phase != sdspi_pkg::PH_IDLE) begin
                r.cs_active = seq_sel;
                r.status    = sdspi_pkg::ST_BUSY;
                return r;
            end
            seq_count  = '0;
            seq_polls  = '0;
            seq_status = sdspi_pkg::ST_OK;
            if (b.kind == sdspi_pkg::CMD_IDLE) begin
                seq_sel   = 1'b0;
                seq_phase = sdspi_pkg::PH_DUMMY;
                seq_count = 13'd1;
                return send_byte(r, sdspi_pkg::BYTE_IDLE);
            end
            seq_sel = b.sel;
            if (b.kind == sdspi_pkg::CMD_COMMAND) begin
                rl = b.rsp_len;
                if (rl < 3'd1) rl = 3'd1;
                if (rl > 3'(sdspi_pkg::RESP_MAX)) rl = 3'(sdspi_pkg::RESP_MAX);
                seq_resp_tgt = rl;
                seq_frame    = {sdspi_pkg::CMD_PREFIX, b.cmd_idx, b.arg, b.crc};
                seq_phase    = sdspi_pkg::PH_CPRE;
            end else begin
                dl = b.blk_len;
                if (dl == '0) dl = 13'd1;
                if (dl > 13'(MAX_BLOCK_BYTES)) dl = 13'(MAX_BLOCK_BYTES);
                seq_data_tgt = dl;
                seq_phase    = sdspi_pkg::PH_RPRE;
            end
            return send_byte(r, sdspi_pkg::BYTE_IDLE);
        end
        case (seq_phase)
            sdspi_pkg::PH_DUMMY: begin
                lim = (cfg_idle_clks == '0) ? 8'd1 : cfg_idle_clks;
                if (seq_count >= 13'(lim)) begin
                    seq_phase = sdspi_pkg::PH_IDLE;
                    r.done    = 1'b1;
                    r.status  = sdspi_pkg::ST_OK;
                end else begin
                    seq_count = seq_count + 1'b1;
                    r = send_byte(r, sdspi_pkg::BYTE_IDLE);
                end
            end
            sdspi_pkg::PH_CPRE: begin
                seq_phase = sdspi_pkg::PH_CFRAME;
                seq_count = '0;
                r = send_byte(r, frame_byte(13'd0));
            end
            sdspi_pkg::PH_CFRAME: begin
                seq_count = seq_count + 1'b1;
                if (seq_count < 13'(sdspi_pkg::FRAME_BYTES)) begin
                    r = send_byte(r, frame_byte(seq_count));
                end else begin
                    seq_phase = sdspi_pkg::PH_CPOLL;
                    seq_polls = 8'd1;
                    r = send_byte(r, sdspi_pkg::BYTE_IDLE);
                end
            end
            sdspi_pkg::PH_CPOLL: begin
                if ((b.rx & sdspi_pkg::MASK_RESP) == '0) begin
                    if (seq_resp_tgt <= 3'd1) begin
                        r = got_byte(r, b.rx, 1'b0, 1'b1);
                        r = finish_tail(r, sdspi_pkg::ST_OK);
                    end else begin
                        r = got_byte(r, b.rx, 1'b0, 1'b0);
                        seq_count = 13'd1;
                        seq_phase = sdspi_pkg::PH_CRESP;
                        r = send_byte(r, sdspi_pkg::BYTE_IDLE);
                    end
                end else begin
                    lim = (cfg_poll_limit == '0) ? 8'd1 : cfg_poll_limit;
                    if (seq_polls >= lim) begin
                        r = finish_tail(r, sdspi_pkg::ST_NORESP);
                    end else begin
                        seq_polls = seq_polls + 1'b1;
                        r = send_byte(r, sdspi_pkg::BYTE_IDLE);
                    end
                end
            end
            sdspi_pkg::PH_CRESP: begin
                seq_count = seq_count + 1'b1;
                if (seq_count >= 13'(seq_resp_tgt)) begin
                    r = got_byte(r, b.rx, 1'b0, 1'b1);
                    r = finish_tail(r, sdspi_pkg::ST_OK);
                end else begin
                    r = got_byte(r, b.rx, 1'b0, 1'b0);
                    r = send_byte(r, sdspi_pkg::BYTE_IDLE);
                end
            end
            sdspi_pkg::PH_RPRE: begin
                seq_phase = sdspi_pkg::PH_RWAIT;
                r = send_byte(r, sdspi_pkg::BYTE_IDLE);
            end
            sdspi_pkg::PH_RWAIT: begin
                if ((b.rx & sdspi_pkg::MASK_ERR_TOK) == '0) begin
                    r = finish_tail(r, sdspi_pkg::ST_DATAERR);
                end else begin
                    if (b.rx == sdspi_pkg::TOKEN_START) begin
                        seq_phase = sdspi_pkg::PH_RDATA;
                        seq_count = '0;
                    end
                    r = send_byte(r, sdspi_pkg::BYTE_IDLE);
                end
            end
            sdspi_pkg::PH_RDATA: begin
                seq_count = seq_count + 1'b1;
                if (seq_count >= seq_data_tgt) begin
                    r = got_byte(r, b.rx, 1'b1, 1'b1);
                    seq_phase = sdspi_pkg::PH_RCRC;
                    seq_count = '0;
                end else begin
                    r = got_byte(r, b.rx, 1'b1, 1'b0);
                end
                r = send_byte(r, sdspi_pkg::BYTE_IDLE);
            end
            sdspi_pkg::PH_RCRC: begin
                seq_count = seq_count + 1'b1;
                if (seq_count >= 13'(sdspi_pkg::CRC_BYTES))
                    r = finish_tail(r, sdspi_pkg::ST_OK);
                else
                    r = send_byte(r, sdspi_pkg::BYTE_IDLE);
            end
            sdspi_pkg::PH_TAIL: begin
                seq_phase = sdspi_pkg::PH_IDLE;
                seq_sel   = 1'b0;
                r.done    = 1'b1;
                r.status  = seq_status;
            end
            default: begin
                seq_phase = sdspi_pkg::PH_IDLE;
            end
        endcase
        return r;
    endfunction

    task automatic note_mismatch(string msg);
        mismatches++;
        $display("mismatch at result beat %0d: %s", n_results, msg);
    endtask

    task automatic field_cmp(string name, longint got, longint want);
        if (got != want)
            note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic compare_reply(sdspi_pkg::t_result got, sdspi_pkg::t_result want);
        field_cmp("tx_valid", got.tx_valid, want.tx_valid);
        field_cmp("tx_byte", got.tx_byte, want.tx_byte);
        field_cmp("cs_active", got.cs_active, want.cs_active);
        field_cmp("out_valid", got.out_valid, want.out_valid);
        field_cmp("out_byte", got.out_byte, want.out_byte);
        field_cmp("out_is_data", got.out_is_data, want.out_is_data);
        field_cmp("out_last", got.out_last, want.out_last);
        field_cmp("done_res", got.done, want.done);
        field_cmp("status", got.status, want.status);
    endtask

    always @(posedge i_clk) begin
        sdspi_pkg::t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got             = '0;
            got.tx_valid    = m_axis_tdata[0];
            got.tx_byte     = m_axis_tdata[8:1];
            got.cs_active   = m_axis_tdata[9];
            got.out_valid   = m_axis_tdata[10];
            got.out_byte    = m_axis_tdata[18:11];
            got.done        = m_axis_tdata[19];
            got.status      = sdspi_pkg::t_status'(m_axis_tdata[21:20]);
            got.out_is_data = m_axis_tuser;
            got.out_last    = m_axis_tlast;
            if (pending_replies.size() == 0)
                note_mismatch("result beat with nothing expected");
            else
                compare_reply(got, pending_replies.pop_front());
            n_results++;
        end
        if (!i_rst_n || (m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 11);
    end

    task automatic send_beat(t_spi_in b, bit typed, sdspi_pkg::t_result want);
        sdspi_pkg::t_result pred;
        while (!calm && $urandom_range(99) < 11) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, b.rx, b.sel, b.blk_len, b.rsp_len, b.crc, b.arg, b.cmd_idx};
        s_axis_tuser  <= b.kind;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        pred = spi_sequence_step(b);
        pending_replies.push_back(typed ? want : pred);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic hold_off(int unsigned cycles);
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(negedge i_clk);
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic write_reg(sdspi_pkg::t_reg idx, logic [7:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        if (idx == sdspi_pkg::REG_POLL_LIMIT)
            cfg_poll_limit = v;
        else
            cfg_idle_clks = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic sdspi_pkg::t_result reply(logic done, sdspi_pkg::t_status st, logic cs);
        sdspi_pkg::t_result r;
        r           = '0;
        r.done      = done;
        r.status    = st;
        r.cs_active = cs;
        return r;
    endfunction

    function automatic void req(sdspi_pkg::t_cmd k, logic [5:0] idx, logic [31:0] arg,
                                logic [7:0] crc, logic [2:0] rl, logic [12:0] dl, logic sel,
                                bit typed, sdspi_pkg::t_result want);
        t_plan_row p;
        p.b     = '{k, idx, arg, crc, rl, dl, sel, 8'h00};
        p.typed = typed;
        p.want  = want;
        plan.push_back(p);
    endfunction

    function automatic void xb(logic [7:0] rx, bit typed, sdspi_pkg::t_result want);
        t_plan_row p;
        p.b     = '{sdspi_pkg::CMD_XCHG, 6'd0, 32'd0, 8'd0, 3'd0, 13'd0, 1'b0, rx};
        p.typed = typed;
        p.want  = want;
        plan.push_back(p);
    endfunction

    function automatic t_spi_in random_beat();
        t_spi_in     b;
        int unsigned pick;
        int unsigned lpick;
        b.kind     = sdspi_pkg::CMD_XCHG;
        b.cmd_idx  = 6'($urandom);
        b.arg      = $urandom;
        b.crc      = 8'($urandom);
        b.rsp_len  = 3'($urandom_range(0, 7));
        b.sel      = 1'($urandom);
        b.rx       = 8'($urandom);
        lpick      = $urandom_range(99);
        if (lpick < 90)
            b.blk_len = 13'($urandom_range(0, 12));
        else
            b.blk_len = 13'($urandom_range(13, 300));
        pick = $urandom_range(99);
        if (seq_phase == sdspi_pkg::PH_IDLE) begin
            if (pick < 45) begin
                b.kind = sdspi_pkg::CMD_COMMAND;
            end else if (pick < 80) begin
                b.kind = sdspi_pkg::CMD_READ;
            end else if (pick < 92) begin
                b.kind = sdspi_pkg::CMD_IDLE;
            end
        end else if (pick < 3) begin
            b.kind = sdspi_pkg::t_cmd'($urandom_range(0, 2));
        end else begin
            pick = $urandom_range(99);
            case (seq_phase)
                sdspi_pkg::PH_CPOLL: b.rx[7] = (pick >= 25);
                sdspi_pkg::PH_RWAIT: begin
                    if (pick < 35)
                        b.rx = sdspi_pkg::TOKEN_START;
                    else if (pick < 45)
                        b.rx[7:5] = 3'b000;
                    else if (b.rx[7:5] == 3'b000)
                        b.rx[7] = 1'b1;
                end
                default: ;
            endcase
        end
        return b;
    endfunction

    initial begin
        logic [7:0] poll_set [N_SETTINGS];
        logic [7:0] idle_set [N_SETTINGS];
        poll_set = '{8'd8, 8'd1, 8'd255, 8'd0, 8'($urandom), 8'($urandom)};
        idle_set = '{8'd10, 8'd1, 8'd255, 8'd0, 8'($urandom_range(1, 20)), 8'($urandom)};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        xb(8'hFF, 1'b1, reply(1'b0, sdspi_pkg::ST_OK, 1'b0));
        foreach (plan[i]) send_beat(plan[i].b, plan[i].typed, plan[i].want);
        plan.delete();
        hold_off(4);
        write_reg(sdspi_pkg::REG_POLL_LIMIT, 8'd2);
        write_reg(sdspi_pkg::REG_IDLE_CLKS, 8'd1);

        req(sdspi_pkg::CMD_IDLE, 6'd0, 32'd0, 8'd0, 3'd1, 13'd1, 1'b1, 1'b0, '0);
        xb(8'h00, 1'b1, reply(1'b1, sdspi_pkg::ST_OK, 1'b0));
        req(sdspi_pkg::CMD_COMMAND, 6'd0, 32'd0, 8'h95, 3'd0, 13'd0, 1'b1, 1'b0, '0);
        xb(8'hFF, 1'b0, '0);
        xb(8'hFF, 1'b0, '0);
        xb(8'h00, 1'b0, '0);
        xb(8'hFF, 1'b0, '0);
        xb(8'h00, 1'b0, '0);
        xb(8'hFF, 1'b0, '0);
        xb(8'hFF, 1'b0, '0);
        req(sdspi_pkg::CMD_READ, 6'd0, 32'd0, 8'd0, 3'd1, 13'd1, 1'b0, 1'b1,
            reply(1'b0, sdspi_pkg::ST_BUSY, 1'b1));
        xb(8'h01, 1'b0, '0);
        xb(8'hFF, 1'b1, reply(1'b1, sdspi_pkg::ST_OK, 1'b0));
        req(sdspi_pkg::CMD_READ, 6'd0, 32'd0, 8'd0, 3'd1, 13'd0, 1'b1, 1'b0, '0);
        xb(8'hFF, 1'b0, '0);
        xb(sdspi_pkg::TOKEN_START, 1'b0, '0);
        xb(8'hA5, 1'b0, '0);
        xb(8'h12, 1'b0, '0);
        xb(8'h34, 1'b0, '0);
        xb(8'hFF, 1'b1, reply(1'b1, sdspi_pkg::ST_OK, 1'b0));
        req(sdspi_pkg::CMD_READ, 6'h3F, 32'hFFFF_FFFF, 8'hFF, 3'd7, 13'h1FFF, 1'b1, 1'b0, '0);
        xb(8'hFF, 1'b0, '0);
        xb(8'h1F, 1'b0, '0);
        xb(8'hFF, 1'b1, reply(1'b1, sdspi_pkg::ST_DATAERR, 1'b0));
        foreach (plan[i]) send_beat(plan[i].b, plan[i].typed, plan[i].want);

        for (int unsigned s = 0; s < N_SETTINGS; s++) begin
            hold_off(4);
            write_reg(sdspi_pkg::REG_POLL_LIMIT, poll_set[s]);
            write_reg(sdspi_pkg::REG_IDLE_CLKS, idle_set[s]);
            while (n_items < (s + 1) * ITEMS / N_SETTINGS
                   || seq_phase != sdspi_pkg::PH_IDLE) begin
                calm = (n_items >= ITEMS / 2) && (n_items < ITEMS / 2 + 300);
                send_beat(random_beat(), 1'b0, '0);
            end
        end
        calm = 1'b0;
        hold_off(DRAIN_CYCLES);

        if (mismatches == 0 && pending_replies.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/sdspi_pkg.sv
hdl/sdspi_front.sv
hdl/sdspi_queue.sv
hdl/sdspi_back.sv
hdl/sd_spi_transaction_engine.sv
tb/tb.sv
